// ===== sv/lhr_pkg.sv =====
package lhr_pkg;

  // default sizing
  localparam int unsigned ALPHABET_SIZE_DEF = 26;
  localparam int unsigned COUNT_BITS_DEF    = 32;

  // input item kinds carried in tuser
  localparam int unsigned MODE_W = 2;
  typedef enum logic [MODE_W-1:0] {
    MODE_CHAR = 2'd0,
    MODE_WORD = 2'd1,
    MODE_RANK = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // first letter of the alphabet
  localparam logic [7:0] CHAR_BASE = 8'h61;

  // result field widths
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RANK_W      = 5;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned OUT_FIELD_W = RANK_W + LETTER_W + TOTAL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

// ===== sv/letter_histogram_ranker.sv =====
// Letter histogram with ranking. Input items carry a kind in in_tuser and a
// character byte in in_tdata: a character in 'a' up to 'a' + ALPHABET_SIZE - 1
// bumps that letter's saturating count, a word mark bumps the saturating word
// total, a rank command emits ALPHABET_SIZE results in rank order (largest
// count first, ties to the lower letter), out_tlast on the final one. With no
// word seen yet the stored order (a, b, c, ... after reset) is sent unchanged
// and out_tuser is 0; otherwise the order is recomputed and out_tuser is 1.
// Characters and word marks are taken one per cycle, back to back. A rank
// command holds off input until its last result is taken: the recompute
// walks the count memory once per letter through its single read port, then
// each result takes two dependent memory reads (rank order, then count) and
// the output register, and waits out any output stall. No clearing pass is
// needed after reset.
module letter_histogram_ranker #(
  parameter int unsigned ALPHABET_SIZE = lhr_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned COUNT_BITS    = lhr_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lhr_pkg::CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic [lhr_pkg::MODE_W-1:0]      in_tuser,   // [1:0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] rank_position, [9:5] letter_index, [41:10] letter_total, rest zero
  output logic [lhr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // [0] order_updated
  output logic                            out_tlast   // last_of_run
);

  import lhr_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDI  = 8'b0000_0010,
    S_GETI = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_RDO  = 8'b0001_0000,
    S_RDC  = 8'b0010_0000,
    S_LOAD = 8'b0100_0000,
    S_HOLD = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  logic [IDX_W-1:0]      rank_r, rank_nxt;
  logic [IDX_W-1:0]      let_r, let_nxt;
  logic [COUNT_BITS-1:0] ci_r, ci_nxt;
  logic [COUNT_BITS-1:0] word_total_r, word_total_nxt;
  logic                  upd_r, upd_nxt;

  // rank order memory, entries never written hold the identity order
  logic [IDX_W-1:0]         ord_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] ord_vld_r;
  logic [IDX_W-1:0]         ord_q_r;
  logic                     ord_qv_r;
  logic                     ord_we;

  // output register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_upd_r;
  logic                   out_last_r;

  logic                  in_acc;
  mode_t                 in_mode;
  logic [CHAR_W-1:0]     char_ofs;
  logic                  letter_hit;
  logic                  cnt_inc;
  logic [IDX_W-1:0]      cnt_rd_idx;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  ahead;
  logic [IDX_W-1:0]      ord_letter;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_mode    = mode_t'(in_tuser);
  assign char_ofs   = in_tdata - CHAR_BASE;
  assign letter_hit = (in_mode == MODE_CHAR) && (in_tdata >= CHAR_BASE) &&
                      (char_ofs < CHAR_W'(ALPHABET_SIZE));
  assign cnt_inc    = in_acc && letter_hit;

  assign out_tvalid = (state_r == S_HOLD);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;
  assign out_tlast  = out_last_r;

  // letter j ranks ahead of letter i
  assign ahead = (cnt_rd > ci_r) || ((cnt_rd == ci_r) && (j_r < i_r));

  assign ord_letter = ord_qv_r ? ord_q_r : k_r;
  assign ord_we     = (state_r == S_SCAN) && (j_r == LAST_IDX);

  // count memory address
  always_comb begin
    case (state_r)
      S_IDLE:  cnt_rd_idx = letter_hit ? IDX_W'(char_ofs) : '0;
      S_RDI:   cnt_rd_idx = i_r;
      S_GETI:  cnt_rd_idx = '0;
      S_SCAN:  cnt_rd_idx = (j_r == LAST_IDX) ? '0 : j_r + IDX_W'(1);
      S_RDC:   cnt_rd_idx = ord_letter;
      default: cnt_rd_idx = '0;
    endcase
  end

  lhr_count_store #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_count_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (cnt_rd_idx),
    .inc_en   (cnt_inc),
    .rd_count (cnt_rd)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    rank_nxt       = rank_r;
    let_nxt        = let_r;
    ci_nxt         = ci_r;
    word_total_nxt = word_total_r;
    upd_nxt        = upd_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_WORD)) begin
          if (word_total_r != {COUNT_BITS{1'b1}}) begin
            word_total_nxt = word_total_r + COUNT_BITS'(1);
          end
        end
        if (in_acc && (in_mode == MODE_RANK)) begin
          i_nxt = '0;
          k_nxt = '0;
          if (word_total_r != '0) begin
            upd_nxt   = 1'b1;
            state_nxt = S_RDI;
          end else begin
            upd_nxt   = 1'b0;
            state_nxt = S_RDO;
          end
        end
      end
      S_RDI: begin
        state_nxt = S_GETI;
      end
      S_GETI: begin
        ci_nxt    = cnt_rd;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_SCAN;
      end
      // count the letters ahead of letter i, one per cycle
      S_SCAN: begin
        rank_nxt = rank_r + IDX_W'(ahead);
        if (j_r == LAST_IDX) begin
          if (i_r == LAST_IDX) begin
            k_nxt     = '0;
            state_nxt = S_RDO;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_RDI;
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_RDO: begin
        state_nxt = S_RDC;
      end
      S_RDC: begin
        let_nxt   = ord_letter;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_tready) begin
          if (k_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_RDO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      word_total_r <= '0;
      ord_vld_r    <= '0;
      ord_qv_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_total_r <= word_total_nxt;
      if (ord_we) begin
        ord_vld_r[rank_nxt] <= 1'b1;
      end
      ord_qv_r     <= ord_vld_r[k_r];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    rank_r <= rank_nxt;
    let_r  <= let_nxt;
    ci_r   <= ci_nxt;
    upd_r  <= upd_nxt;
  end

  // rank order memory
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[rank_nxt] <= i_r;
    end
    ord_q_r <= ord_mem[k_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      out_data_r <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), TOTAL_W'(cnt_rd),
                     LETTER_W'(let_r), RANK_W'(k_r)};
      out_upd_r  <= upd_r;
      out_last_r <= (k_r == LAST_IDX);
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_last_at_final_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[RANK_W-1:0] == RANK_W'(ALPHABET_SIZE - 1)))
    else $error("last flag not on the final rank position");

  a_rank_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rank_r <= j_r))
    else $error("rank count exceeds letters scanned");
`endif

endmodule

// ===== sv/lhr_count_store.sv =====
module lhr_count_store #(
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned COUNT_BITS    = 32,
  localparam int unsigned IDX_W        = $clog2(ALPHABET_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IDX_W-1:0]      rd_idx,    // read address, every cycle
  input  logic                  inc_en,    // increment the entry read this cycle
  output logic [COUNT_BITS-1:0] rd_count   // count at the address of the last cycle
);

  logic [COUNT_BITS-1:0] cnt_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] cnt_vld_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  mem_qv_r;

  // increment stage
  logic                  s1_vld_r;
  logic [IDX_W-1:0]      s1_idx_r;

  // last write, for a read that met it at the same edge
  logic                  fwd_vld_r;
  logic [IDX_W-1:0]      fwd_idx_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_new;

  // entries never written read as zero
  assign rd_count = mem_qv_r ? mem_q_r : '0;

  // forwarded or stored value, then saturating increment
  always_comb begin
    if (fwd_vld_r && (fwd_idx_r == s1_idx_r)) begin
      cnt_cur = fwd_data_r;
    end else begin
      cnt_cur = rd_count;
    end
    if (cnt_cur == {COUNT_BITS{1'b1}}) begin
      cnt_new = cnt_cur;
    end else begin
      cnt_new = cnt_cur + COUNT_BITS'(1);
    end
  end

  // count memory, one read and one write port
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      cnt_mem[s1_idx_r] <= cnt_new;
    end
    mem_q_r    <= cnt_mem[rd_idx];
    s1_idx_r   <= rd_idx;
    fwd_idx_r  <= s1_idx_r;
    fwd_data_r <= cnt_new;
  end

  // valid bits and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      mem_qv_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (s1_vld_r) begin
        cnt_vld_r[s1_idx_r] <= 1'b1;
      end
      mem_qv_r  <= cnt_vld_r[rd_idx];
      s1_vld_r  <= inc_en;
      fwd_vld_r <= s1_vld_r;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lhr_pkg::*;

  localparam int ALPHA     = ALPHABET_SIZE_DEF;
  localparam int COUNT_W   = COUNT_BITS_DEF;
  localparam int WATCHDOG  = 4000;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM  = 440;
  localparam int CALM_FROM = 380;

  localparam logic [7:0] LAST_LETTER = CHAR_BASE + 8'(ALPHA - 1);
  localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

  // one ranking result as it should leave the block
  typedef struct {
    logic [RANK_W-1:0]   pos;
    logic [LETTER_W-1:0] letter;
    logic [TOTAL_W-1:0]  total;
    logic                updated;
    logic                last;
  } ranking_t;

  // directed row: typed rows carry a ranking read straight off the spec
  // (identity order, every total equal)
  typedef struct {
    mode_t              kind;
    logic [7:0]         code;
    logic               typed;
    logic               t_updated;
    logic [TOTAL_W-1:0] t_total;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [CHAR_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  // sideband travelling with each driven item
  logic               item_typed = 1'b0;
  logic               item_t_upd = 1'b0;
  logic [TOTAL_W-1:0] item_t_total = '0;

  // predictor state
  logic [COUNT_W-1:0]  letter_tally [ALPHA];
  logic [COUNT_W-1:0]  words_seen;
  logic [LETTER_W-1:0] standing [ALPHA];

  ranking_t pending_ranks [$];

  int errors = 0;
  int items_taken = 0;
  int ranks_taken = 0;
  int ranks_refreshed = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int cycle_no = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_RANK, 8'h00,           1'b1, 1'b0, '0},
    '{MODE_CHAR, CHAR_BASE - 8'd1, 1'b0, 1'b0, '0},
    '{MODE_CHAR, LAST_LETTER + 8'd1, 1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'h00,           1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'hff,           1'b0, 1'b0, '0},
    '{MODE_NONE, CHAR_BASE,       1'b0, 1'b0, '0},
    '{MODE_NONE, 8'hff,           1'b0, 1'b0, '0},
    '{MODE_RANK, 8'hff,           1'b1, 1'b0, '0},
    '{MODE_CHAR, LAST_LETTER,     1'b0, 1'b0, '0},
    '{MODE_CHAR, CHAR_BASE,       1'b0, 1'b0, '0},
    '{MODE_CHAR, LAST_LETTER,     1'b0, 1'b0, '0},
    '{MODE_RANK, 8'h00,           1'b0, 1'b0, '0},
    '{MODE_WORD, 8'hff,           1'b0, 1'b0, '0},
    '{MODE_RANK, 8'h00,           1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'h6d,           1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'h6d,           1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'h6d,           1'b0, 1'b0, '0},
    '{MODE_CHAR, 8'h41,           1'b0, 1'b0, '0},
    '{MODE_WORD, 8'h00,           1'b0, 1'b0, '0},
    '{MODE_RANK, 8'h00,           1'b0, 1'b0, '0},
    '{MODE_RANK, 8'hff,           1'b0, 1'b0, '0}
  };

  letter_histogram_ranker #(
    .ALPHABET_SIZE(ALPHA),
    .COUNT_BITS   (COUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // larger count first, ties to the lower letter
  function automatic bit outranks(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b);
    if (letter_tally[a] != letter_tally[b]) begin
      return letter_tally[a] > letter_tally[b];
    end
    return a < b;
  endfunction

  // advance the histogram on one accepted item, queue any ranking it causes
  function automatic void count_and_rank(input mode_t kind, input logic [7:0] code,
                                         input logic typed, input logic t_upd,
                                         input logic [TOTAL_W-1:0] t_total);
    int i;
    int j;
    logic [LETTER_W-1:0] cur;
    logic refreshed;
    ranking_t r;
    case (kind)
      MODE_CHAR: begin
        if (code >= CHAR_BASE && int'(code - CHAR_BASE) < ALPHA) begin
          i = int'(code - CHAR_BASE);
          if (letter_tally[i] != COUNT_TOP) letter_tally[i] = letter_tally[i] + 1'b1;
        end
      end
      MODE_WORD: begin
        if (words_seen != COUNT_TOP) words_seen = words_seen + 1'b1;
      end
      MODE_RANK: begin
        refreshed = (words_seen != '0);
        ranks_taken++;
        if (refreshed) begin
          ranks_refreshed++;
          for (i = 0; i < ALPHA; i++) standing[i] = LETTER_W'(i);
          // stable insertion sort
          for (i = 1; i < ALPHA; i++) begin
            cur = standing[i];
            j = i;
            while (j > 0 && outranks(cur, standing[j-1])) begin
              standing[j] = standing[j-1];
              j--;
            end
            standing[j] = cur;
          end
        end
        for (i = 0; i < ALPHA; i++) begin
          r.pos     = RANK_W'(i);
          r.letter  = typed ? LETTER_W'(i) : standing[i];
          r.total   = typed ? t_total : letter_tally[standing[i]][TOTAL_W-1:0];
          r.updated = typed ? t_upd : refreshed;
          r.last    = (i == ALPHA - 1);
          pending_ranks.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // predictor update and result check at every edge
  always @(posedge clk) begin
    ranking_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        items_taken++;
        count_and_rank(mode_t'(in_tuser), in_tdata, item_typed, item_t_upd, item_t_total);
      end
      if (out_tvalid && out_tready) begin
        if (pending_ranks.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual tdata %h", $time,
                   out_tdata);
        end else begin
          want = pending_ranks.pop_front();
          results_checked++;
          check_field("rank_position", 32'(want.pos), 32'(out_tdata[RANK_W-1:0]));
          check_field("letter_index", 32'(want.letter),
                      32'(out_tdata[RANK_W+LETTER_W-1:RANK_W]));
          check_field("letter_total", 32'(want.total),
                      32'(out_tdata[OUT_FIELD_W-1:RANK_W+LETTER_W]));
          check_field("tdata padding", 32'd0,
                      32'(out_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
          check_field("order_updated", 32'(want.updated), 32'(out_tuser));
          check_field("last_of_run", 32'(want.last), 32'(out_tlast));
        end
      end
    end
  end

  // receiver stalls in bursts, with quiet stretches and none near the end
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (!calm && cycle_no[8] == 1'b0 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // no progress on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: %0d cycles without progress at %0t ns", idle_cycles, $time);
        $display("letter_histogram_ranker regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // drive one item, with an occasional gap before it, and wait for acceptance
  task automatic send_item(input mode_t kind, input logic [7:0] code, input logic typed,
                           input logic t_upd, input logic [TOTAL_W-1:0] t_total);
    if (!calm && (items_taken % 64) < 48 && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= kind;
    in_tdata     <= code;
    item_typed   <= typed;
    item_t_upd   <= t_upd;
    item_t_total <= t_total;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // random letter: mostly a few favorites so that ties and close counts occur
  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 2) == 0) return CHAR_BASE + 8'($urandom_range(0, ALPHA - 1));
    return CHAR_BASE + 8'($urandom_range(0, 5) * 3);
  endfunction

  initial begin
    int n;
    int pick;
    for (n = 0; n < ALPHA; n++) begin
      letter_tally[n] = '0;
      standing[n] = LETTER_W'(n);
    end
    words_seen = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (n = 0; n < N_DIRECTED; n++) begin
      send_item(directed_rows[n].kind, directed_rows[n].code, directed_rows[n].typed,
                directed_rows[n].t_updated, directed_rows[n].t_total);
    end

    // random text: letters and word marks, some rank commands, some noise
    n = 0;
    while (n < N_RANDOM) begin
      calm = (n >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_item(MODE_CHAR, pick_letter(), 1'b0, 1'b0, '0);
      end else if (pick < 84) begin
        send_item(MODE_WORD, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end else if (pick < 88) begin
        send_item(MODE_RANK, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end else if (pick < 96) begin
        send_item(MODE_CHAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end else begin
        send_item(MODE_NONE, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
      n++;
    end
    send_item(MODE_RANK, 8'h00, 1'b0, 1'b0, '0);
    in_tvalid <= 1'b0;

    // drain, then give stray results a chance to show up
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("accepted %0d items, %0d rank commands (%0d with a fresh order)",
             items_taken, ranks_taken, ranks_refreshed);
    $display("checked %0d ranking results field by field, %0d mismatches",
             results_checked, errors);
    if (errors == 0) begin
      $display("letter_histogram_ranker regression: pass");
    end else begin
      $display("letter_histogram_ranker regression: fail");
    end
    $finish;
  end

endmodule
